// ===== rtl/bitmap_page_frame_allocator_macros.svh =====
// assertion macros for the bitmap page frame allocator
// expects clk and rst to be visible where a macro is used
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// condition implies expression in the same cycle
`define BPFA_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// condition implies expression in the next cycle
`define BPFA_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== rtl/bpfa_pkg.sv =====
// shared types and constants for the bitmap page frame allocator
// no dependencies
`default_nettype none

package bpfa_pkg;

  localparam logic [2:0] KIND_INIT        = 3'd0;
  localparam logic [2:0] KIND_ALLOC       = 3'd1;
  localparam logic [2:0] KIND_FREE_PAGE   = 3'd2;
  localparam logic [2:0] KIND_FREE_REGION = 3'd3;
  localparam logic [2:0] KIND_RESERVE     = 3'd4;

  localparam logic [15:0] TOTAL_RESET = 16'd32768;
  localparam logic [15:0] USED_RESET  = 16'd32768;
  localparam logic [7:0]  FULL_WORD   = 8'hFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [26:0] byte_address;
    logic [27:0] byte_length;
  } in_item_t;

  typedef struct packed {
    logic [26:0] alloc_address;
    logic        alloc_ok;
    logic [15:0] used_count;
  } out_item_t;

  typedef enum logic [1:0] {
    WOP_ALLOC,
    WOP_CLEAR,
    WOP_SET
  } word_op_t;

  typedef struct packed {
    word_op_t    op;
    logic [16:0] base;
    logic [15:0] lo;
    logic [15:0] hi;
  } word_req_t;

  typedef struct packed {
    logic [7:0] new_word;
    logic [3:0] flips;
    logic       found;
    logic [2:0] found_bit;
  } word_upd_t;

endpackage

`default_nettype wire

// ===== rtl/bpfa_bitmap_ram.sv =====
// used-bit map storage, one byte of page bits per entry
// one write port, one read port with registered data; no dependencies
`default_nettype none

module bpfa_bitmap_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfa_word_update.sv =====
// modify step for one bitmap byte: range set or clear, or lowest free bit
// depends on bpfa_pkg
`default_nettype none

module bpfa_word_update (
  input  wire bpfa_pkg::word_req_t req,
  input  wire logic [7:0]          data,
  output bpfa_pkg::word_upd_t      upd
);

  logic [7:0]  mask;
  logic [7:0]  flip_bits;
  logic [7:0]  pick;
  logic [16:0] page;
  logic [3:0]  cnt;
  logic        any;
  logic [2:0]  low;

  always_comb begin
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      page = req.base + 17'(b);
      mask[b] = (page >= {1'b0, req.lo}) && (page < {1'b0, req.hi});
    end
  end

  always_comb begin
    any = 1'b0;
    low = '0;
    for (int b = 7; b >= 0; b--) begin
      if (~data[b] & mask[b]) begin
        any = 1'b1;
        low = 3'(b);
      end
    end
    pick = any ? (8'd1 << low) : 8'd0;
  end

  always_comb begin
    case (req.op)
      bpfa_pkg::WOP_ALLOC: flip_bits = pick;
      bpfa_pkg::WOP_CLEAR: flip_bits = data & mask;
      bpfa_pkg::WOP_SET:   flip_bits = ~data & mask;
      default:             flip_bits = '0;
    endcase
    cnt = '0;
    for (int b = 0; b < 8; b++) begin
      cnt = cnt + 4'(flip_bits[b]);
    end
    upd.new_word  = data ^ flip_bits;
    upd.flips     = cnt;
    upd.found     = any;
    upd.found_bit = low;
  end

endmodule

`default_nettype wire

// ===== rtl/bpfa_cfg_regs.sv =====
// configuration register file, holds the managed page total
// depends on bpfa_pkg
`default_nettype none

module bpfa_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [15:0] total_page_count
);

  localparam logic [1:0] ADDR_TOTAL = 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_page_count <= bpfa_pkg::TOTAL_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_TOTAL) begin
      total_page_count <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TOTAL) ? 32'(total_page_count) : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator.sv =====
// top level of the bitmap page frame allocator: request sequencer around the map ram
// depends on bpfa_pkg, bpfa_cfg_regs, bpfa_bitmap_ram, bpfa_word_update
//
//   port       | dir | transfer
//   in_data    | in  | one request, kind plus byte address and length
//   out_data   | out | one result per request, address, ok flag, used count
//   apb        | in  | page total register at byte address 0
//
// each map byte takes a ram read, then a modify and write back (alloc writes only the byte it allocates from)
// alloc: scans bytes up to the first free page
// region and free page: a read and a write back per byte touched; init: one map byte per cycle
// after reset a clearing pass sets all (MAX_PAGES+7)/8 bytes, one per cycle, no input taken
// a waiting result holds the sequencer in its done state until out_stall drops
`default_nettype none
`include "bitmap_page_frame_allocator_macros.svh"

module bitmap_page_frame_allocator #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bpfa_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bpfa_pkg::out_item_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int MAP_WORDS  = (MAX_PAGES + 7) / 8;
  localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int CAP        = (MAX_PAGES > 65535) ? 65535 : MAX_PAGES;
  localparam logic [15:0]   CAP16     = 16'(CAP);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD,
    S_DONE
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_idx;
  logic                init_op;
  bpfa_pkg::word_req_t req;
  logic [15:0]         used_cnt;
  logic [15:0]         used_next;
  logic [26:0]         res_addr;
  logic                res_ok;

  logic [15:0]         total_page_count;
  logic [15:0]         eff_total;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  bpfa_pkg::word_upd_t upd;

  logic [29:0]         start_pg;
  logic [29:0]         span;
  logic [29:0]         stop_pg;
  logic [15:0]         stop_cap;
  logic                range_empty;
  logic [16:0]         next_base;
  logic [16:0]         sum17;
  logic [16:0]         found_page;

  bpfa_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .total_page_count (total_page_count)
  );

  bpfa_bitmap_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bpfa_word_update u_upd (
    .req  (req),
    .data (rd_data),
    .upd  (upd)
  );

  assign eff_total = (total_page_count > CAP16) ? CAP16 : total_page_count;
  assign in_stall  = (state != S_IDLE);

  // page range of a region or single page request
  always_comb begin
    start_pg = 30'(in_data.byte_address >> PAGE_SHIFT);
    case (in_data.kind)
      bpfa_pkg::KIND_FREE_REGION: span = 30'(in_data.byte_length >> PAGE_SHIFT);
      bpfa_pkg::KIND_RESERVE:
        span = 30'((29'(in_data.byte_length) + 29'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
      default: span = 30'd1;
    endcase
    stop_pg     = start_pg + span;
    stop_cap    = (stop_pg > 30'(eff_total)) ? eff_total : stop_pg[15:0];
    range_empty = (start_pg >= 30'(stop_cap));
  end

  always_comb begin
    next_base  = req.base + 17'd8;
    found_page = req.base + 17'(upd.found_bit);
    sum17      = {1'b0, used_cnt} + 17'(upd.flips);
    if (req.op == bpfa_pkg::WOP_CLEAR) begin
      used_next = (used_cnt < 16'(upd.flips)) ? 16'd0 : used_cnt - 16'(upd.flips);
    end else begin
      used_next = sum17[16] ? 16'hFFFF : sum17[15:0];
    end
  end

  always_comb begin
    rd_en   = (state == S_READ);
    rd_addr = AW'(req.base >> 3);
    wr_en   = 1'b0;
    wr_addr = AW'(req.base >> 3);
    wr_data = upd.new_word;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = bpfa_pkg::FULL_WORD;
    end else if (state == S_MOD) begin
      wr_en = (req.op != bpfa_pkg::WOP_ALLOC) || upd.found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      init_op    <= 1'b0;
      used_cnt   <= bpfa_pkg::USED_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_WORD) begin
            state <= init_op ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_addr <= '0;
            res_ok   <= 1'b0;
            case (in_data.kind)
              bpfa_pkg::KIND_INIT: begin
                clr_idx    <= '0;
                init_op    <= 1'b1;
                used_cnt   <= eff_total;
                state      <= S_CLEAR;
              end
              bpfa_pkg::KIND_ALLOC: begin
                req.op   <= bpfa_pkg::WOP_ALLOC;
                req.base <= '0;
                req.lo   <= '0;
                req.hi   <= eff_total;
                state    <= (eff_total == 16'd0) ? S_DONE : S_READ;
              end
              bpfa_pkg::KIND_FREE_PAGE, bpfa_pkg::KIND_FREE_REGION,
              bpfa_pkg::KIND_RESERVE: begin
                req.op   <= (in_data.kind == bpfa_pkg::KIND_RESERVE) ?
                            bpfa_pkg::WOP_SET : bpfa_pkg::WOP_CLEAR;
                req.base <= {1'b0, start_pg[15:3], 3'b000};
                req.lo   <= start_pg[15:0];
                req.hi   <= stop_cap;
                state    <= range_empty ? S_DONE : S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_MOD;
        end
        S_MOD: begin
          used_cnt <= used_next;
          if (req.op == bpfa_pkg::WOP_ALLOC && upd.found) begin
            res_addr <= 27'(48'(found_page) << PAGE_SHIFT);
            res_ok   <= 1'b1;
            state    <= S_DONE;
          end else if (next_base < {1'b0, req.hi}) begin
            req.base <= next_base;
            state    <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          init_op <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.alloc_address <= res_addr;
            out_data.alloc_ok      <= res_ok;
            out_data.used_count    <= used_cnt;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BPFA_ASSERT_NOW(a_no_write_idle, state == S_IDLE || state == S_DONE, !wr_en, "map written outside a request")
  `BPFA_ASSERT_NOW(a_fail_addr_zero, out_valid && !out_data.alloc_ok, out_data.alloc_address == 27'd0, "failed result carries an address")
  `BPFA_ASSERT_NEXT(a_sweep_whole, state == S_CLEAR && clr_idx != LAST_WORD, state == S_CLEAR, "clearing pass cut short")
  `BPFA_ASSERT_NEXT(a_result_from_done, state != S_DONE && !out_valid, !out_valid, "result shown without a finished request")

endmodule

`default_nettype wire
